### design/lcwd_pkg.sv
// Shared types and constants for the LCW (Format80) decompressor.
// Used by lcwd_ctrl and lcw_decompressor_top; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lcwd_pkg;

  // Item operation codes.
  localparam logic [1:0] OP_SRC  = 2'd0;
  localparam logic [1:0] OP_PULL = 2'd1;
  localparam logic [1:0] OP_NEW  = 2'd2;
  localparam logic [1:0] OP_BAD  = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_RUN    = 2'd0;
  localparam logic [1:0] ST_DONE   = 2'd1;
  localparam logic [1:0] ST_ERROR  = 2'd2;
  localparam logic [1:0] ST_REJECT = 2'd3;

  // Configuration register indexes.
  localparam logic REG_OUT_LIMIT = 1'b0;
  localparam logic REG_REL_MODE  = 1'b1;

  localparam int          CFG_W         = 17;
  localparam int          CNT_W         = 17;
  localparam logic [16:0] LIMIT_RESET   = 17'h10000;

  // Command byte fields.
  localparam logic [5:0] CODE_FILL  = 6'h3E;
  localparam logic [5:0] CODE_LONG  = 6'h3F;
  localparam logic [3:0] COPY_BIAS  = 4'd3;

  typedef enum logic [13:0] {
    PH_CMD        = 14'h0001,
    PH_SHORT2     = 14'h0002,
    PH_LIT        = 14'h0004,
    PH_FILL_C0    = 14'h0008,
    PH_FILL_C1    = 14'h0010,
    PH_FILL_V     = 14'h0020,
    PH_LONG_C0    = 14'h0040,
    PH_LONG_C1    = 14'h0080,
    PH_POS0       = 14'h0100,
    PH_POS1       = 14'h0200,
    PH_DRAIN_COPY = 14'h0400,
    PH_DRAIN_FILL = 14'h0800,
    PH_DONE       = 14'h1000,
    PH_ERROR      = 14'h2000
  } phase_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] src_byte;
    logic       src_last;
  } in_item_t;

  typedef struct packed {
    logic             out_valid;
    logic [7:0]       out_byte;
    logic             want_byte;
    logic [1:0]       status;
    logic [CNT_W-1:0] out_count;
  } out_item_t;

  // Decode result of one item, carried into the output stage.
  typedef struct packed {
    logic             byte_valid;
    logic             from_mem;
    logic [7:0]       lit_byte;
    logic             wr_en;
    logic [15:0]      wr_addr;
    logic [15:0]      rd_addr;
    logic             want_byte;
    logic [1:0]       status;
    logic [CNT_W-1:0] count;
  } step_res_t;

  function automatic logic needs_source(phase_t ph);
    return !(ph == PH_DRAIN_COPY || ph == PH_DRAIN_FILL || ph == PH_DONE ||
             ph == PH_ERROR);
  endfunction

endpackage

`default_nettype wire

### design/lcwd_hist.sv
// Output history memory of the LCW decompressor: one write port, one
// registered read port. Depends on nothing beyond its parameters.
`timescale 1ns / 1ps
`default_nettype none

module lcwd_hist #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### design/lcwd_ctrl.sv
// Command decoder and run control of the LCW decompressor, plus the
// configuration registers. Depends on lcwd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lcwd_ctrl #(
  parameter int OUT_DEPTH = 65536
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic                      cfg_index,
  input  wire logic [lcwd_pkg::CFG_W-1:0] cfg_wdata,
  input  wire logic                      adv,
  input  wire lcwd_pkg::in_item_t        item,
  output lcwd_pkg::step_res_t            res
);

  localparam logic [16:0] DEPTH17 = 17'(OUT_DEPTH);

  lcwd_pkg::phase_t phase_r, phase_nxt;
  logic [16:0] wcount_r, wcount_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [15:0] run_r, run_nxt;
  logic [15:0] from_r, from_nxt;
  logic [7:0]  fillv_r, fillv_nxt;
  logic [15:0] gath_r, gath_nxt;
  logic        srcend_r, srcend_nxt;
  logic [16:0] limit_r;
  logic        relmode_r;

  logic [16:0] eff_lim;
  logic [17:0] lim18;
  logic [17:0] d18;
  logic [3:0]  short_cnt;
  logic [11:0] short_dist;
  logic [15:0] pos;
  logic [16:0] src_pos;
  logic        rejected;
  logic        put;
  logic [7:0]  put_byte;
  logic        ended;

  function automatic lcwd_pkg::phase_t go_next(lcwd_pkg::phase_t nx, logic src_end);
    if (lcwd_pkg::needs_source(nx) && src_end) begin
      return lcwd_pkg::PH_ERROR;
    end
    return nx;
  endfunction

  always_comb begin
    eff_lim    = (limit_r > DEPTH17) ? DEPTH17 : limit_r;
    lim18      = {1'b0, eff_lim};
    d18        = {1'b0, wcount_r};
    short_cnt  = {1'b0, cmd_r[6:4]} + lcwd_pkg::COPY_BIAS;
    short_dist = {cmd_r[3:0], item.src_byte};
    pos        = {item.src_byte, gath_r[7:0]};
    src_pos    = relmode_r ? (wcount_r - {1'b0, pos}) : {1'b0, pos};
    ended      = item.src_last;

    phase_nxt  = phase_r;
    wcount_nxt = wcount_r;
    cmd_nxt    = cmd_r;
    run_nxt    = run_r;
    from_nxt   = from_r;
    fillv_nxt  = fillv_r;
    gath_nxt   = gath_r;
    srcend_nxt = srcend_r;
    rejected   = 1'b0;
    put        = 1'b0;
    put_byte   = 8'h00;
    res        = '0;
    res.rd_addr = from_r;
    res.wr_addr = wcount_r[15:0];

    if (item.op == lcwd_pkg::OP_NEW) begin
      phase_nxt  = lcwd_pkg::PH_CMD;
      wcount_nxt = '0;
      cmd_nxt    = '0;
      run_nxt    = '0;
      from_nxt   = '0;
      fillv_nxt  = '0;
      gath_nxt   = '0;
      srcend_nxt = 1'b0;
    end else if (item.op == lcwd_pkg::OP_BAD) begin
      rejected = 1'b1;
    end else if (phase_r == lcwd_pkg::PH_DONE || phase_r == lcwd_pkg::PH_ERROR) begin
      // A finished or failed frame ignores all but a new frame; a bad item is still rejected.
    end else if (item.op == lcwd_pkg::OP_SRC) begin
      if (!lcwd_pkg::needs_source(phase_r)) begin
        rejected = 1'b1;
      end else begin
        srcend_nxt = ended;
        unique case (phase_r)
          lcwd_pkg::PH_CMD: begin
            cmd_nxt = item.src_byte;
            if (!item.src_byte[7]) begin
              phase_nxt = go_next(lcwd_pkg::PH_SHORT2, ended);
            end else if (!item.src_byte[6]) begin
              if (item.src_byte[5:0] == 6'd0) begin
                phase_nxt = lcwd_pkg::PH_DONE;
              end else if (d18 + 18'(item.src_byte[5:0]) > lim18) begin
                phase_nxt = lcwd_pkg::PH_ERROR;
              end else begin
                run_nxt   = 16'(item.src_byte[5:0]);
                phase_nxt = go_next(lcwd_pkg::PH_LIT, ended);
              end
            end else if (item.src_byte[5:0] == lcwd_pkg::CODE_FILL) begin
              phase_nxt = go_next(lcwd_pkg::PH_FILL_C0, ended);
            end else if (item.src_byte[5:0] == lcwd_pkg::CODE_LONG) begin
              phase_nxt = go_next(lcwd_pkg::PH_LONG_C0, ended);
            end else begin
              run_nxt   = 16'(item.src_byte[5:0]) + 16'(lcwd_pkg::COPY_BIAS);
              phase_nxt = go_next(lcwd_pkg::PH_POS0, ended);
            end
          end
          lcwd_pkg::PH_SHORT2: begin
            // A short copy that would overrun the limit ends the frame cleanly.
            if (d18 + 18'(short_cnt) > lim18) begin
              phase_nxt = lcwd_pkg::PH_DONE;
            end else if (short_dist == 12'd0 || 17'(short_dist) > wcount_r) begin
              phase_nxt = lcwd_pkg::PH_ERROR;
            end else begin
              from_nxt  = 16'(wcount_r - 17'(short_dist));
              run_nxt   = 16'(short_cnt);
              phase_nxt = lcwd_pkg::PH_DRAIN_COPY;
            end
          end
          lcwd_pkg::PH_LIT: begin
            put      = 1'b1;
            put_byte = item.src_byte;
            if (run_r != 16'd0) begin
              run_nxt = run_r - 16'd1;
            end
            phase_nxt = go_next((run_nxt != 16'd0) ? lcwd_pkg::PH_LIT : lcwd_pkg::PH_CMD,
                                ended);
          end
          lcwd_pkg::PH_FILL_C0: begin
            gath_nxt  = {8'h00, item.src_byte};
            phase_nxt = go_next(lcwd_pkg::PH_FILL_C1, ended);
          end
          lcwd_pkg::PH_FILL_C1: begin
            gath_nxt  = {item.src_byte, gath_r[7:0]};
            phase_nxt = go_next(lcwd_pkg::PH_FILL_V, ended);
          end
          lcwd_pkg::PH_FILL_V: begin
            fillv_nxt = item.src_byte;
            if (d18 + 18'(gath_r) > lim18) begin
              phase_nxt = lcwd_pkg::PH_ERROR;
            end else if (gath_r == 16'd0) begin
              phase_nxt = go_next(lcwd_pkg::PH_CMD, ended);
            end else begin
              run_nxt   = gath_r;
              phase_nxt = lcwd_pkg::PH_DRAIN_FILL;
            end
          end
          lcwd_pkg::PH_LONG_C0: begin
            gath_nxt  = {8'h00, item.src_byte};
            phase_nxt = go_next(lcwd_pkg::PH_LONG_C1, ended);
          end
          lcwd_pkg::PH_LONG_C1: begin
            run_nxt   = {item.src_byte, gath_r[7:0]};
            phase_nxt = go_next(lcwd_pkg::PH_POS0, ended);
          end
          lcwd_pkg::PH_POS0: begin
            gath_nxt  = {8'h00, item.src_byte};
            phase_nxt = go_next(lcwd_pkg::PH_POS1, ended);
          end
          lcwd_pkg::PH_POS1: begin
            gath_nxt = pos;
            if (relmode_r && ({1'b0, pos} > wcount_r)) begin
              phase_nxt = lcwd_pkg::PH_ERROR;
            end else if (src_pos >= wcount_r || d18 + 18'(run_r) > lim18) begin
              phase_nxt = lcwd_pkg::PH_ERROR;
            end else if (run_r == 16'd0) begin
              phase_nxt = go_next(lcwd_pkg::PH_CMD, ended);
            end else begin
              from_nxt  = src_pos[15:0];
              phase_nxt = lcwd_pkg::PH_DRAIN_COPY;
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
    end else begin
      if (lcwd_pkg::needs_source(phase_r)) begin
        rejected = 1'b1;
      end else begin
        put = 1'b1;
        if (phase_r == lcwd_pkg::PH_DRAIN_COPY) begin
          res.from_mem = 1'b1;
          from_nxt     = from_r + 16'd1;
        end else begin
          put_byte = fillv_r;
        end
        if (run_r != 16'd0) begin
          run_nxt = run_r - 16'd1;
        end
        if (run_nxt == 16'd0) begin
          phase_nxt = go_next(lcwd_pkg::PH_CMD, srcend_r);
        end
      end
    end

    if (put) begin
      res.byte_valid = 1'b1;
      res.lit_byte   = put_byte;
      if (wcount_r < DEPTH17) begin
        res.wr_en  = 1'b1;
        wcount_nxt = wcount_r + 17'd1;
      end
    end

    if (rejected) begin
      res.status = lcwd_pkg::ST_REJECT;
    end else if (phase_nxt == lcwd_pkg::PH_DONE) begin
      res.status = lcwd_pkg::ST_DONE;
    end else if (phase_nxt == lcwd_pkg::PH_ERROR) begin
      res.status = lcwd_pkg::ST_ERROR;
    end else begin
      res.status = lcwd_pkg::ST_RUN;
    end
    res.want_byte = lcwd_pkg::needs_source(phase_nxt);
    res.count     = wcount_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= lcwd_pkg::PH_CMD;
      wcount_r  <= '0;
      cmd_r     <= '0;
      run_r     <= '0;
      from_r    <= '0;
      fillv_r   <= '0;
      gath_r    <= '0;
      srcend_r  <= 1'b0;
      limit_r   <= lcwd_pkg::LIMIT_RESET;
      relmode_r <= 1'b0;
    end else begin
      if (adv) begin
        phase_r  <= phase_nxt;
        wcount_r <= wcount_nxt;
        cmd_r    <= cmd_nxt;
        run_r    <= run_nxt;
        from_r   <= from_nxt;
        fillv_r  <= fillv_nxt;
        gath_r   <= gath_nxt;
        srcend_r <= srcend_nxt;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          lcwd_pkg::REG_OUT_LIMIT: limit_r   <= cfg_wdata[16:0];
          lcwd_pkg::REG_REL_MODE:  relmode_r <= cfg_wdata[0];
          default:                 limit_r   <= limit_r;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

### design/lcw_decompressor_top.sv
// Top level of the LCW (Format80) decompressor: decoder, history memory and
// output stage. Depends on lcwd_pkg, lcwd_ctrl and lcwd_hist.
`timescale 1ns / 1ps
`default_nettype none

// Takes one transaction per clock and returns exactly one result transaction
// for each, in order, in the cycle after acceptance. The decoder updates its
// state in the accept cycle and launches the history read for a copy byte;
// the byte comes out of the history memory (one write port, one registered
// read port) in the next cycle, in the output register, and is written back to
// the history when its result transaction completes. A copy at distance one
// reads the entry that is being written in that same cycle; that byte is
// forwarded, so a copy still runs at one byte per pull. The input stalls only
// while a result waits on out_ready.
// History entries are undefined after reset and need no clearing pass, since
// a frame only reads what it has already written.
module lcw_decompressor_top #(
  parameter int OUT_DEPTH = 65536
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic                       cfg_index,
  input  wire logic [lcwd_pkg::CFG_W-1:0] cfg_wdata,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire lcwd_pkg::in_item_t         in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output lcwd_pkg::out_item_t             out_data
);

  localparam int AW = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;

  lcwd_pkg::step_res_t res;
  lcwd_pkg::step_res_t s2_r;
  logic                s2_v_r;
  logic                fwd_r, fwd_nxt;
  logic [7:0]          fwd_data_r;
  logic [7:0]          rd_data;
  logic [7:0]          s2_byte;
  logic                adv;
  logic                out_xfer;
  logic                hist_we;

  assign in_ready = !s2_v_r || out_ready;
  assign adv      = in_valid && in_ready;
  assign out_xfer = s2_v_r && out_ready;
  assign hist_we  = out_xfer && s2_r.wr_en;

  lcwd_ctrl #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .adv       (adv),
    .item      (in_data),
    .res       (res)
  );

  lcwd_hist #(
    .DEPTH (OUT_DEPTH),
    .AW    (AW)
  ) u_hist (
    .clk     (clk),
    .wr_en   (hist_we),
    .wr_addr (s2_r.wr_addr[AW-1:0]),
    .wr_data (s2_byte),
    .rd_en   (adv),
    .rd_addr (res.rd_addr[AW-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    if (!s2_r.byte_valid) begin
      s2_byte = 8'h00;
    end else if (s2_r.from_mem) begin
      s2_byte = fwd_r ? fwd_data_r : rd_data;
    end else begin
      s2_byte = s2_r.lit_byte;
    end
    // The memory returns the old entry when it is written in the read cycle.
    fwd_nxt = s2_v_r && s2_r.wr_en && res.from_mem && (s2_r.wr_addr == res.rd_addr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= 1'b1;
    end else if (out_ready) begin
      s2_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r       <= res;
      fwd_r      <= fwd_nxt;
      fwd_data_r <= s2_byte;
    end
  end

  always_comb begin
    out_valid          = s2_v_r;
    out_data.out_valid = s2_r.byte_valid;
    out_data.out_byte  = s2_byte;
    out_data.want_byte = s2_r.want_byte;
    out_data.status    = s2_r.status;
    out_data.out_count = s2_r.count;
  end

`ifndef ASSERT_OFF
  a_no_byte_on_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_valid |-> out_data.status != lcwd_pkg::ST_REJECT)
    else $error("rejected transaction carries an output byte");

  a_byte_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_valid |-> out_data.out_count != '0)
    else $error("output byte reported with a zero output count");

  a_mem_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && s2_r.from_mem |-> s2_r.byte_valid && s2_r.wr_en)
    else $error("history read for a result that emits no byte");

  a_fwd_copy: assert property (@(posedge clk) disable iff (!rst_n)
    adv && fwd_nxt |=> s2_r.from_mem && fwd_r)
    else $error("forwarded byte not used by a copy result");
`endif

endmodule

`default_nettype wire

### sim/tb_lcw_decompressor_top.sv
// Self-checking testbench for lcw_decompressor_top: random LCW frames against a built-in decoder.
// Depends on lcwd_pkg and the design files under design/.
`timescale 1ns / 1ps

module tb_lcw_decompressor_top;

  localparam int unsigned DEPTH = 65536;
  localparam logic [7:0] LIT_BASE  = 8'h80;
  localparam logic [7:0] END_MARK  = 8'h80;
  localparam logic [7:0] MED_BASE  = 8'hC0;
  localparam logic [7:0] FILL_CMD  = {2'b11, lcwd_pkg::CODE_FILL};
  localparam logic [7:0] LONG_CMD  = {2'b11, lcwd_pkg::CODE_LONG};
  localparam int unsigned HOLD_LEN = 150;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_we = 1'b0;
  logic                       cfg_index = 1'b0;
  logic [lcwd_pkg::CFG_W-1:0] cfg_wdata = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  lcwd_pkg::in_item_t         in_data = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  lcwd_pkg::out_item_t        out_data;

  lcw_decompressor_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  // Decoder state mirrored by the testbench.
  logic [7:0]        hist_mem [0:DEPTH-1];
  int unsigned       wr_cnt;
  lcwd_pkg::phase_t  dec_phase;
  logic [7:0]        cmd_byte;
  int unsigned       run_left;
  int unsigned       copy_src;
  int unsigned       gathered;
  logic [7:0]        fill_byte;
  bit                src_done;
  int unsigned       limit_reg;
  bit                rel_mode;

  lcwd_pkg::in_item_t  pend_items[$];
  lcwd_pkg::out_item_t exp_results[$];

  int unsigned pushed_cnt = 0;
  int unsigned acc_cnt = 0;
  int unsigned res_cnt = 0;
  int unsigned bytes_cnt = 0;
  int unsigned frames_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;
  int unsigned hold_left = 0;
  int unsigned next_hold_at = 0;

  // Generator's view of the frame being built.
  int unsigned g_cnt = 0;
  int unsigned g_lim = DEPTH;
  bit          g_rel = 1'b0;

  function automatic int min2(int a, int b);
    return (a < b) ? a : b;
  endfunction

  function automatic bit wants_src(lcwd_pkg::phase_t p);
    return !(p == lcwd_pkg::PH_DRAIN_COPY || p == lcwd_pkg::PH_DRAIN_FILL ||
             p == lcwd_pkg::PH_DONE || p == lcwd_pkg::PH_ERROR);
  endfunction

  // Running out of source turns any phase that still needs a byte into an error.
  function automatic lcwd_pkg::phase_t go_next(lcwd_pkg::phase_t nxt);
    return (wants_src(nxt) && src_done) ? lcwd_pkg::PH_ERROR : nxt;
  endfunction

  function automatic void restart_frame();
    wr_cnt    = 0;
    dec_phase = lcwd_pkg::PH_CMD;
    cmd_byte  = '0;
    run_left  = 0;
    copy_src  = 0;
    fill_byte = '0;
    gathered  = 0;
    src_done  = 1'b0;
  endfunction

  function automatic logic [7:0] put_byte(logic [7:0] v);
    if (wr_cnt < DEPTH) begin
      hist_mem[wr_cnt] = v;
      wr_cnt++;
    end
    return v;
  endfunction

  function automatic lcwd_pkg::out_item_t decode_item(lcwd_pkg::in_item_t it);
    lcwd_pkg::out_item_t r;
    bit          rej;
    int unsigned d, lim, cnt, back_dist, s;
    logic [7:0]  b;
    r   = '0;
    rej = 1'b0;
    b   = it.src_byte;
    d   = wr_cnt;
    lim = (limit_reg > DEPTH) ? DEPTH : limit_reg;
    if (it.op == lcwd_pkg::OP_NEW) begin
      restart_frame();
    end else if (it.op == lcwd_pkg::OP_BAD) begin
      rej = 1'b1;
    end else if (dec_phase != lcwd_pkg::PH_DONE && dec_phase != lcwd_pkg::PH_ERROR) begin
      if ((it.op == lcwd_pkg::OP_SRC) != wants_src(dec_phase)) begin
        rej = 1'b1;
      end else if (it.op == lcwd_pkg::OP_SRC) begin
        src_done = it.src_last;
        case (dec_phase)
          lcwd_pkg::PH_CMD: begin
            cmd_byte = b;
            if (!b[7]) begin
              dec_phase = go_next(lcwd_pkg::PH_SHORT2);
            end else if (!b[6]) begin
              cnt = b[5:0];
              if (cnt == 0) dec_phase = lcwd_pkg::PH_DONE;
              else if (d + cnt > lim) dec_phase = lcwd_pkg::PH_ERROR;
              else begin
                run_left  = cnt;
                dec_phase = go_next(lcwd_pkg::PH_LIT);
              end
            end else if (b[5:0] == lcwd_pkg::CODE_FILL) begin
              dec_phase = go_next(lcwd_pkg::PH_FILL_C0);
            end else if (b[5:0] == lcwd_pkg::CODE_LONG) begin
              dec_phase = go_next(lcwd_pkg::PH_LONG_C0);
            end else begin
              run_left  = int'(b[5:0]) + lcwd_pkg::COPY_BIAS;
              dec_phase = go_next(lcwd_pkg::PH_POS0);
            end
          end
          lcwd_pkg::PH_SHORT2: begin
            cnt       = int'(cmd_byte[6:4]) + lcwd_pkg::COPY_BIAS;
            back_dist = {cmd_byte[3:0], b};
            if (d + cnt > lim) dec_phase = lcwd_pkg::PH_DONE;
            else if (back_dist == 0 || back_dist > d) dec_phase = lcwd_pkg::PH_ERROR;
            else begin
              copy_src  = d - back_dist;
              run_left  = cnt;
              dec_phase = lcwd_pkg::PH_DRAIN_COPY;
            end
          end
          lcwd_pkg::PH_LIT: begin
            r.out_byte  = put_byte(b);
            r.out_valid = 1'b1;
            if (run_left > 0) run_left--;
            dec_phase = go_next((run_left != 0) ? lcwd_pkg::PH_LIT : lcwd_pkg::PH_CMD);
          end
          lcwd_pkg::PH_FILL_C0: begin
            gathered  = b;
            dec_phase = go_next(lcwd_pkg::PH_FILL_C1);
          end
          lcwd_pkg::PH_FILL_C1: begin
            gathered  = gathered | (32'(b) << 8);
            dec_phase = go_next(lcwd_pkg::PH_FILL_V);
          end
          lcwd_pkg::PH_FILL_V: begin
            fill_byte = b;
            if (d + gathered > lim) dec_phase = lcwd_pkg::PH_ERROR;
            else if (gathered == 0) dec_phase = go_next(lcwd_pkg::PH_CMD);
            else begin
              run_left  = gathered;
              dec_phase = lcwd_pkg::PH_DRAIN_FILL;
            end
          end
          lcwd_pkg::PH_LONG_C0: begin
            gathered  = b;
            dec_phase = go_next(lcwd_pkg::PH_LONG_C1);
          end
          lcwd_pkg::PH_LONG_C1: begin
            run_left  = gathered | (32'(b) << 8);
            dec_phase = go_next(lcwd_pkg::PH_POS0);
          end
          lcwd_pkg::PH_POS0: begin
            gathered  = b;
            dec_phase = go_next(lcwd_pkg::PH_POS1);
          end
          default: begin
            gathered = gathered | (32'(b) << 8);
            if (rel_mode && gathered > d) begin
              dec_phase = lcwd_pkg::PH_ERROR;
            end else begin
              s = rel_mode ? d - gathered : gathered;
              if (s >= d || d + run_left > lim) dec_phase = lcwd_pkg::PH_ERROR;
              else if (run_left == 0) dec_phase = go_next(lcwd_pkg::PH_CMD);
              else begin
                copy_src  = s;
                dec_phase = lcwd_pkg::PH_DRAIN_COPY;
              end
            end
          end
        endcase
      end else begin
        if (dec_phase == lcwd_pkg::PH_DRAIN_COPY) begin
          b        = hist_mem[copy_src[15:0]];
          copy_src = (copy_src + 1) & 32'hFFFF;
        end else begin
          b = fill_byte;
        end
        r.out_byte  = put_byte(b);
        r.out_valid = 1'b1;
        if (run_left > 0) run_left--;
        if (run_left == 0) dec_phase = go_next(lcwd_pkg::PH_CMD);
      end
    end

    if (rej) r.status = lcwd_pkg::ST_REJECT;
    else if (dec_phase == lcwd_pkg::PH_DONE) r.status = lcwd_pkg::ST_DONE;
    else if (dec_phase == lcwd_pkg::PH_ERROR) r.status = lcwd_pkg::ST_ERROR;
    else r.status = lcwd_pkg::ST_RUN;
    r.want_byte = wants_src(dec_phase);
    r.out_count = lcwd_pkg::CNT_W'(wr_cnt);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_cnt++;
  endtask

  // Input driver: a new transaction is offered only once the previous one is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        exp_results.push_back(decode_item(in_data));
        acc_cnt++;
      end
      if (!in_valid || in_ready) begin
        if (pend_items.size() != 0 && $urandom_range(99, 0) >= snd_idle_pct) begin
          in_data  <= pend_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, so the block backs up and stalls its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left    <= 0;
      next_hold_at <= 400;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (acc_cnt >= next_hold_at) begin
      hold_left    <= HOLD_LEN;
      next_hold_at <= next_hold_at + 700;
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    lcwd_pkg::out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        res_cnt++;
        if (exp_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", res_cnt));
        end else begin
          want = exp_results.pop_front();
          if (out_data.out_valid != want.out_valid)
            report_mismatch($sformatf("result %0d out_valid exp %0d got %0d", res_cnt,
                                      want.out_valid, out_data.out_valid));
          if (out_data.out_byte != want.out_byte)
            report_mismatch($sformatf("result %0d out_byte exp %02h got %02h", res_cnt,
                                      want.out_byte, out_data.out_byte));
          if (out_data.want_byte != want.want_byte)
            report_mismatch($sformatf("result %0d want_byte exp %0d got %0d", res_cnt,
                                      want.want_byte, out_data.want_byte));
          if (out_data.status != want.status)
            report_mismatch($sformatf("result %0d status exp %0d got %0d", res_cnt,
                                      want.status, out_data.status));
          if (out_data.out_count != want.out_count)
            report_mismatch($sformatf("result %0d out_count exp %0d got %0d", res_cnt,
                                      want.out_count, out_data.out_count));
          if (want.out_valid) bytes_cnt++;
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99, 0) >= rcv_idle_pct);
    end
  end

  task automatic push_item(logic [1:0] op, logic [7:0] b, logic last);
    lcwd_pkg::in_item_t it;
    it.op       = op;
    it.src_byte = b;
    it.src_last = last;
    pend_items.push_back(it);
    pushed_cnt++;
  endtask

  task automatic push_src(logic [7:0] b);
    push_item(lcwd_pkg::OP_SRC, b, 1'b0);
  endtask

  task automatic push_word(int unsigned v);
    push_src(v[7:0]);
    push_src(v[15:8]);
  endtask

  // Pulls for a drain, with the odd source byte slipped in that must be turned away.
  task automatic push_pulls(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(19, 0) == 0)
        push_item(lcwd_pkg::OP_SRC, 8'($urandom), 1'($urandom));
      push_item(lcwd_pkg::OP_PULL, 8'($urandom), 1'($urandom));
    end
  endtask

  function automatic int unsigned pick_pos();
    return g_rel ? $urandom_range(g_cnt, 1) : $urandom_range(g_cnt - 1, 0);
  endfunction

  task automatic gen_frame(int n_cmds);
    int room, sel, hi, n, cnt, back_dist, k;
    push_item(lcwd_pkg::OP_NEW, 8'($urandom), 1'($urandom));
    g_cnt = 0;
    frames_cnt++;
    for (int c = 0; c < n_cmds; c++) begin
      room = g_lim - g_cnt;
      if (room == 0) break;
      sel = $urandom_range(99, 0);
      if (g_cnt == 0 || room < 3) sel = (sel < 90) ? 0 : 95;
      if (sel < 30) begin
        hi = min2(room, 8);
        if ($urandom_range(9, 0) == 0) hi = min2(room, 63);
        n = $urandom_range(hi, 1);
        push_src(LIT_BASE | 8'(n));
        repeat (n) push_src(8'($urandom));
        g_cnt += n;
      end else if (sel < 55) begin
        cnt       = $urandom_range(min2(room, 10), 3);
        back_dist = $urandom_range(min2(g_cnt, 4095), 1);
        push_src({1'b0, 3'(cnt - 3), 4'(back_dist >> 8)});
        push_src(8'(back_dist));
        push_pulls(cnt);
        g_cnt += cnt;
      end else if (sel < 70) begin
        hi = min2(room, 12);
        if ($urandom_range(9, 0) == 0) hi = min2(room, 64);
        cnt = $urandom_range(hi, 3);
        push_src(MED_BASE | 8'(cnt - 3));
        push_word(pick_pos());
        push_pulls(cnt);
        g_cnt += cnt;
      end else if (sel < 80) begin
        cnt = $urandom_range(min2(room, 16), 0);
        push_src(FILL_CMD);
        push_word(cnt);
        push_src(8'($urandom));
        push_pulls(cnt);
        g_cnt += cnt;
      end else if (sel < 90) begin
        cnt = $urandom_range(min2(room, 16), 0);
        push_src(LONG_CMD);
        push_word(cnt);
        push_word(pick_pos());
        push_pulls(cnt);
        g_cnt += cnt;
      end else if ($urandom_range(1, 0) == 0) begin
        push_item(lcwd_pkg::OP_BAD, 8'($urandom), 1'($urandom));
      end else begin
        push_item(lcwd_pkg::OP_PULL, 8'($urandom), 1'($urandom));
      end
    end

    room = g_lim - g_cnt;
    case ($urandom_range(7, 0))
      0: push_src(END_MARK);
      1: begin
        // A short copy that overruns the limit ends the frame cleanly.
        if (room <= 9) begin
          cnt = $urandom_range(10, (room < 2) ? 3 : room + 1);
          push_src({1'b0, 3'(cnt - 3), 4'($urandom)});
          push_src(8'($urandom));
        end else push_src(END_MARK);
      end
      2: begin
        if (room >= 10) begin
          cnt       = $urandom_range(10, 3);
          back_dist = (g_cnt < 4095 && $urandom_range(1, 0) == 1)
                      ? $urandom_range(4095, g_cnt + 1) : 0;
          push_src({1'b0, 3'(cnt - 3), 4'(back_dist >> 8)});
          push_src(8'(back_dist));
        end else push_src(END_MARK);
      end
      3: begin
        if (room < 63) push_src(LIT_BASE | 8'($urandom_range(63, room + 1)));
        else push_src(END_MARK);
      end
      4: begin
        // Source runs dry: inside a literal run, or right after a copy command.
        if (g_cnt >= 1 && room >= 3 && $urandom_range(1, 0) == 1) begin
          push_src(8'h00);
          push_item(lcwd_pkg::OP_SRC, 8'h01, 1'b1);
          push_pulls(3);
        end else if (room >= 2) begin
          n = $urandom_range(min2(room, 8), 2);
          k = $urandom_range(n - 1, 0);
          push_src(LIT_BASE | 8'(n));
          for (int i = 0; i <= k; i++) push_item(lcwd_pkg::OP_SRC, 8'($urandom), i == k);
        end else push_item(lcwd_pkg::OP_SRC, END_MARK, 1'b1);
      end
      5: begin
        if (room >= 3) begin
          push_src(MED_BASE);
          if (g_rel) push_word(($urandom_range(1, 0) == 0) ? 0 : $urandom_range(65535, g_cnt + 1));
          else push_word($urandom_range(65535, g_cnt));
        end else push_src(END_MARK);
      end
      6: begin
        if (g_cnt + 65535 > g_lim) begin
          push_src(FILL_CMD);
          push_word(16'hFFFF);
          push_src(8'($urandom));
        end else push_src(END_MARK);
      end
      default: ;
    endcase
    repeat ($urandom_range(3, 0)) push_item(2'($urandom), 8'($urandom), 1'($urandom));
  endtask

  // Returns once every queued transaction is taken and its result checked.
  task automatic wait_idle();
    do @(posedge clk); while (acc_cnt != pushed_cnt || exp_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(int unsigned lim, bit rel);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= lcwd_pkg::REG_OUT_LIMIT;
    cfg_wdata <= lcwd_pkg::CFG_W'(lim);
    @(posedge clk);
    cfg_index <= lcwd_pkg::REG_REL_MODE;
    cfg_wdata <= lcwd_pkg::CFG_W'(rel);
    @(posedge clk);
    cfg_we    <= 1'b0;
    limit_reg = lim;
    rel_mode  = rel;
    g_lim     = (lim > DEPTH) ? DEPTH : lim;
    g_rel     = rel;
  endtask

  task automatic run_phase(int n_items, int unsigned snd_pct, int unsigned rcv_pct);
    int unsigned start;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    start = pushed_cnt;
    while (pushed_cnt - start < n_items / 2) gen_frame($urandom_range(16, 1));
    // The sender stops here until the block has handed back everything.
    wait_idle();
    while (pushed_cnt - start < n_items) gen_frame($urandom_range(16, 1));
    wait_idle();
  endtask

  initial begin
    restart_frame();
    limit_reg = lcwd_pkg::LIMIT_RESET;
    rel_mode  = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    snd_idle_pct = 21;
    rcv_idle_pct = 53;
    write_regs(lcwd_pkg::LIMIT_RESET, 1'b0);

    // Directed frame: each command but the medium copy, plus turned-away transactions.
    push_item(lcwd_pkg::OP_NEW, 8'h00, 1'b0);
    push_src(LIT_BASE | 8'd3);
    push_src(8'h00);
    push_src(8'hFF);
    push_src(8'h5A);
    push_item(lcwd_pkg::OP_PULL, 8'hFF, 1'b1);
    push_src(8'h00);
    push_src(8'h02);
    push_pulls(1);
    push_item(lcwd_pkg::OP_SRC, 8'hFF, 1'b1);
    push_pulls(2);
    push_src(FILL_CMD);
    push_word(2);
    push_src(8'hC3);
    push_pulls(2);
    push_src(LONG_CMD);
    push_word(0);
    push_word(0);
    push_item(lcwd_pkg::OP_BAD, 8'hA5, 1'b0);
    push_item(lcwd_pkg::OP_SRC, END_MARK, 1'b1);
    push_src(8'h7F);
    push_item(lcwd_pkg::OP_PULL, 8'h00, 1'b0);
    wait_idle();

    // Zero limit: any literal is an overrun, any short copy ends the frame.
    write_regs(0, 1'b1);
    push_item(lcwd_pkg::OP_NEW, 8'h00, 1'b0);
    push_src(LIT_BASE | 8'd1);
    push_item(lcwd_pkg::OP_NEW, 8'h00, 1'b0);
    push_src(8'h00);
    push_src(8'h01);
    wait_idle();

    write_regs(lcwd_pkg::LIMIT_RESET, 1'b1);
    run_phase(600, 21, 53);
    write_regs($urandom_range(150, 40), 1'b0);
    run_phase(600, 53, 21);
    write_regs($urandom_range(4000, 200), 1'($urandom));
    run_phase(600, 0, 0);

    $display("Checked %0d transactions in %0d frames, %0d of them carrying decoded bytes,",
             res_cnt, frames_cnt, bytes_cnt);
    $display("with output limits from 0 to 65536 and both copy position modes.");
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("timeout with %0d results still expected", exp_results.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
